// ===== rtl/pvts_pkg.sv =====
package pvts_pkg;

    // Frame store geometry
    localparam int unsigned FRAME_BYTES = 65536;
    localparam int unsigned FB_AW       = $clog2(FRAME_BYTES);

    // Pixel index width and derived palette geometry
    localparam int unsigned COLOR_BITS   = 4;
    localparam int unsigned PAL_ENTRIES  = 1 << COLOR_BITS;

    // Serializer word pieces
    localparam logic [31:0] CLOCK_PATTERN = 32'h0110_0011;
    localparam logic [31:0] DE_FLAG       = 32'h0000_0008;

    // Bit offset within the held byte
    localparam int unsigned PHASE_W = 4;

    // Input opcodes
    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_FB_WRITE  = 2'd1;
    localparam logic [1:0] OP_PAL_WRITE = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LINES  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_LINES   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PIXELS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_PIXELS  = 4'd3;

    // Item held between the timing stage and the colour stage
    typedef struct packed {
        logic                    tick;
        logic                    pal_write;
        logic                    pix_active;
        logic                    fetch;
        logic                    de;
        logic [COLOR_BITS-1:0]   pal_index;
        logic [31:0]             pal_data;
    } t_s1_item;

endpackage

// ===== rtl/palette_video_timing_streamer_core.sv =====
// Palette video timing streamer. Takes one transaction per clock unless the
// output stalls and, for every pixel tick, returns one serializer word via the
// stage and output registers; frame-store and palette writes return nothing.
// The timing stage steps the line and pixel counters and issues a registered
// read of the 64 KiB frame store; the colour stage picks the nibble from the
// fetched or held byte, looks it up in the 16-entry palette and loads the
// output register. The sustained rate, one transaction per cycle while the
// output drains, is set by the single frame-store port (one write or one read
// each cycle). An output register parts the two sides: a transaction is still
// taken while a finished word waits if the colour stage is empty. Configuration
// writes are taken on any cycle and apply to later ticks. The frame store and
// palette are not cleared: read only entries that have been written.
module palette_video_timing_streamer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pvts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [11:0]                   i_cfg_data,
    // input transactions
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_opcode,
    input  logic [15:0]                   i_write_address,
    input  logic [31:0]                   i_write_data,
    // output transactions
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [31:0]                   o_lvds_word,
    output logic                          o_data_enable
);

    localparam int unsigned AW = pvts_pkg::FB_AW;
    localparam int unsigned CB = pvts_pkg::COLOR_BITS;
    localparam int unsigned PW = pvts_pkg::PHASE_W;

    // Configuration registers
    logic [11:0] r_active_lines, r_blank_lines, r_active_pixels, r_blank_pixels;

    // Timing state
    logic [12:0]   r_line, n_line;
    logic [12:0]   r_pixel, n_pixel;
    logic [AW-1:0] r_read_ptr, n_read_ptr;
    logic [PW-1:0] r_phase, n_phase;

    // Colour stage state
    logic [7:0]         r_held, n_held;
    logic [31:0]        r_palette [pvts_pkg::PAL_ENTRIES];
    pvts_pkg::t_s1_item r_s1, n_s1;
    logic               r_s1_valid;

    // Frame store
    logic [7:0] r_frame [pvts_pkg::FRAME_BYTES];
    logic [7:0] r_fb_rdata;

    // Output register
    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic        r_out_de;

    // Handshake and stage control
    logic out_load, s1_adv, s1_fire, in_fire;
    logic is_tick, fb_wr_en, fb_rd_en;
    logic line_active, pixel_active, fetch;
    logic [12:0] line_total, frame_total, pix_next, line_next;
    logic [CB-1:0] col_index;
    logic [7:0]    col_byte;
    logic [31:0]   n_out_word;

    assign o_cfg_ready = 1'b1;

    // Output register loads when empty or drained; stage 1 moves when it is
    // empty or the output can take its result.
    assign out_load = !r_out_valid || i_out_ready;
    assign s1_adv   = !r_s1_valid || out_load;
    assign s1_fire  = r_s1_valid && out_load;
    assign o_in_ready = s1_adv;
    assign in_fire  = i_in_valid && s1_adv;

    assign is_tick  = in_fire && (i_opcode == pvts_pkg::OP_TICK);
    assign fb_wr_en = in_fire && (i_opcode == pvts_pkg::OP_FB_WRITE)
                      && ({1'b0, i_write_address} < 17'(pvts_pkg::FRAME_BYTES));

    // Position decode for the current tick
    assign line_active  = r_line  < {1'b0, r_active_lines};
    assign pixel_active = r_pixel < {1'b0, r_active_pixels};
    assign fetch        = pixel_active && (r_phase[2:0] == 3'd0);
    assign fb_rd_en     = is_tick && fetch;

    assign line_total  = {1'b0, r_active_pixels} + {1'b0, r_blank_pixels};
    assign frame_total = {1'b0, r_active_lines} + {1'b0, r_blank_lines};
    assign pix_next    = r_pixel + 13'd1;
    assign line_next   = r_line + 13'd1;

    // Next timing state: step the pixel, wrap the line, manage the pointer
    always_comb begin
        n_line     = r_line;
        n_pixel    = r_pixel;
        n_read_ptr = r_read_ptr;
        n_phase    = r_phase;
        if (is_tick) begin
            if (pixel_active) begin
                n_phase = PW'(r_phase[2:0]) + PW'(CB);
                if (fetch) begin
                    n_read_ptr = r_read_ptr + AW'(1);
                end
            end else if (!line_active) begin
                // blank pixel of a blank line: rewind to the frame start
                n_read_ptr = '0;
            end
            if (pix_next >= line_total) begin
                n_pixel = '0;
                n_phase = '0;
                n_line  = (line_next >= frame_total) ? 13'd0 : line_next;
            end else begin
                n_pixel = pix_next;
            end
        end
    end

    // Item passed to the colour stage
    always_comb begin
        n_s1.tick       = i_opcode == pvts_pkg::OP_TICK;
        n_s1.pal_write  = i_opcode == pvts_pkg::OP_PAL_WRITE;
        n_s1.pix_active = pixel_active;
        n_s1.fetch      = fetch;
        n_s1.de         = line_active && pixel_active;
        n_s1.pal_index  = i_write_address[CB-1:0];
        n_s1.pal_data   = i_write_data;
    end

    // Colour stage: first nibble of a fresh byte, or the next of the held one
    assign col_byte  = r_s1.fetch ? r_fb_rdata : r_held;
    assign col_index = col_byte[CB-1:0];

    always_comb begin
        n_held     = r_held;
        n_out_word = pvts_pkg::CLOCK_PATTERN;
        if (r_s1.pix_active) begin
            n_held     = 8'(col_byte >> CB);
            n_out_word = n_out_word | r_palette[col_index];
        end
        if (r_s1.de) begin
            n_out_word = n_out_word | pvts_pkg::DE_FLAG;
        end
    end

    // Configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_lines  <= 12'd600;
            r_blank_lines   <= 12'd35;
            r_active_pixels <= 12'd1024;
            r_blank_pixels  <= 12'd320;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pvts_pkg::CFG_ACTIVE_LINES:  r_active_lines  <= i_cfg_data;
                pvts_pkg::CFG_BLANK_LINES:   r_blank_lines   <= i_cfg_data;
                pvts_pkg::CFG_ACTIVE_PIXELS: r_active_pixels <= i_cfg_data;
                pvts_pkg::CFG_BLANK_PIXELS:  r_blank_pixels  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line      <= '0;
            r_pixel     <= '0;
            r_read_ptr  <= '0;
            r_phase     <= '0;
            r_held      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_line     <= n_line;
            r_pixel    <= n_pixel;
            r_read_ptr <= n_read_ptr;
            r_phase    <= n_phase;
            if (s1_fire && r_s1.tick) begin
                r_held <= n_held;
            end
            if (s1_adv) begin
                // frame-store writes finish at acceptance; hold ticks and
                // palette writes so they meet the palette in order
                r_s1_valid <= in_fire && (i_opcode == pvts_pkg::OP_TICK
                                          || i_opcode == pvts_pkg::OP_PAL_WRITE);
            end
            if (out_load) begin
                r_out_valid <= r_s1_valid && r_s1.tick;
            end
        end
    end

    // Stage and output payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1 <= n_s1;
        end
        if (out_load) begin
            r_out_word <= n_out_word;
            r_out_de   <= r_s1.de;
        end
    end

    // Palette: written as its transaction leaves the colour stage
    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1.pal_write) begin
            r_palette[r_s1.pal_index] <= r_s1.pal_data;
        end
    end

    // Frame store: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (fb_wr_en) begin
            r_frame[i_write_address[AW-1:0]] <= i_write_data[7:0];
        end
        if (fb_rd_en) begin
            r_fb_rdata <= r_frame[r_read_ptr];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_lvds_word   = r_out_word;
    assign o_data_enable = r_out_de;

endmodule
